FILE: rtl/text_command_mode_controller_macros.svh
// Assertion macros used by the checker file of the command mode controller.
`ifndef TEXT_COMMAND_MODE_CONTROLLER_MACROS_SVH
`define TEXT_COMMAND_MODE_CONTROLLER_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define TCMC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define TCMC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/tcmc_pkg.sv
// Shared types, constants and helper functions of the command mode controller.
`timescale 1ns / 1ps

package tcmc_pkg;

   // Line buffer length, one slot kept free for the terminating byte.
   localparam int unsigned LINE_BYTES = 64;
   localparam int unsigned COUNT_W    = $clog2(LINE_BYTES);

   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type LINE_LAST = count_type'(LINE_BYTES - 1);

   // Opcodes of an input transaction
   localparam logic OP_BYTE   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] REG_HOT_THRESHOLD    = 2'd0;
   localparam logic [1:0] REG_MOTION_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_AUTO_FAN_DUTY    = 2'd2;
   localparam logic [1:0] REG_MANUAL_FAN_DUTY  = 2'd3;

   // Reset values of the configuration registers
   localparam logic signed [7:0] HOT_THRESHOLD_RST    = 8'sd27;
   localparam logic [11:0]       MOTION_THRESHOLD_RST = 12'd1500;
   localparam logic [9:0]        AUTO_FAN_DUTY_RST    = 10'd500;
   localparam logic [9:0]        MANUAL_FAN_DUTY_RST  = 10'd300;

   localparam logic [9:0] DUTY_MAX = 10'd999;

   // Line terminators
   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_LF  = 8'h0a;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   typedef enum logic [1:0] {
      REPLY_NONE    = 2'd0,
      REPLY_AUTO    = 2'd1,
      REPLY_MANUAL  = 2'd2,
      REPLY_INVALID = 2'd3
   } reply_type;

   // Command table, lowest index wins when several match
   localparam int unsigned NUM_CMDS = 6;
   localparam int unsigned CMD_AUTO    = 0;
   localparam int unsigned CMD_MANUAL  = 1;
   localparam int unsigned CMD_FAN_OFF = 2;
   localparam int unsigned CMD_FAN_ON  = 3;
   localparam int unsigned CMD_LED_OFF = 4;
   localparam int unsigned CMD_LED_ON  = 5;

   // Command text, left aligned, first character in the top byte
   localparam logic [63:0] CMD_TEXT [NUM_CMDS] = '{
      {"AUTO",    32'h0},
      {"MANUEL",  16'h0},
      {"FAN OFF",  8'h0},
      {"FAN ON",  16'h0},
      {"LED OFF",  8'h0},
      {"LED ON",  16'h0}
   };

   localparam count_type CMD_LEN [NUM_CMDS] = '{
      count_type'(4), count_type'(6), count_type'(7),
      count_type'(6), count_type'(7), count_type'(6)
   };

   // Status of the command parser after one transaction
   typedef struct packed {
      reply_type reply;
      logic      manual;
      logic      fan;
      logic      light;
   } cmd_status_type;

   // Character of a command at a position below eight
   function automatic logic [7:0] cmd_char(input logic [63:0] text, input logic [2:0] pos);
      logic [63:0] shifted;
      shifted = text << {pos, 3'b000};
      return shifted[63:56];
   endfunction

   // Duty registers may hold values above the PWM period
   function automatic logic [9:0] clamp_duty(input logic [9:0] duty);
      return (duty > DUTY_MAX) ? DUTY_MAX : duty;
   endfunction

endpackage

FILE: rtl/tcmc_if.sv
// Valid/ready channel interfaces for command and result transactions.
`timescale 1ns / 1ps

interface tcmc_req_if;
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [7:0]        rx_byte;
   logic signed [7:0] temperature;
   logic [11:0]       ir_level;

   modport source (output valid, output opcode, output rx_byte, output temperature,
                   output ir_level, input ready);
   modport sink   (input valid, input opcode, input rx_byte, input temperature,
                   input ir_level, output ready);
endinterface

interface tcmc_rsp_if;
   logic                valid;
   logic                ready;
   logic                result_kind;
   tcmc_pkg::reply_type reply_code;
   logic [9:0]          fan_duty;
   logic                light_on;
   logic                motion_seen;
   logic                manual_active;
   logic                fan_command;
   logic                light_command;

   modport source (output valid, output result_kind, output reply_code, output fan_duty,
                   output light_on, output motion_seen, output manual_active,
                   output fan_command, output light_command, input ready);
   modport sink   (input valid, input result_kind, input reply_code, input fan_duty,
                   input light_on, input motion_seen, input manual_active,
                   input fan_command, input light_command, output ready);
endinterface

FILE: rtl/tcmc_line_parser.sv
// Line assembly, incremental command matching, mode and manual flag state.
`timescale 1ns / 1ps

module tcmc_line_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     byte_item,
   input  logic [7:0]               rx_byte,
   output tcmc_pkg::cmd_status_type status
);

   tcmc_pkg::count_type           count_ff, count_in;
   logic [tcmc_pkg::NUM_CMDS-1:0] match_ff, match_in;
   logic                          ended_ff, ended_in;
   logic                          manual_ff, manual_in;
   logic                          fan_ff, fan_in;
   logic                          light_ff, light_in;

   logic                          do_byte;
   logic                          is_eol;
   logic                          store;
   logic                          finish;
   logic [tcmc_pkg::NUM_CMDS-1:0] keep;
   logic [tcmc_pkg::NUM_CMDS-1:0] hits;
   tcmc_pkg::reply_type           reply;

   assign do_byte = step && byte_item;
   assign is_eol  = (rx_byte == tcmc_pkg::CHAR_CR) || (rx_byte == tcmc_pkg::CHAR_LF);
   assign store   = !is_eol && (count_ff < tcmc_pkg::LINE_LAST);
   assign finish  = !store && (count_ff != '0);

   // Per-command compare of this byte and end-of-line hit vector
   always_comb begin
      for (int k = 0; k < tcmc_pkg::NUM_CMDS; k++) begin
         if (rx_byte == tcmc_pkg::CHAR_NUL) begin
            keep[k] = (tcmc_pkg::CMD_LEN[k] == count_ff);
         end else begin
            keep[k] = (count_ff < tcmc_pkg::CMD_LEN[k]) &&
                      (tcmc_pkg::cmd_char(tcmc_pkg::CMD_TEXT[k], count_ff[2:0]) == rx_byte);
         end
         hits[k] = match_ff[k] && (ended_ff || (tcmc_pkg::CMD_LEN[k] == count_ff));
      end
   end

   // Command decode at line end, first match in table order
   always_comb begin
      reply     = tcmc_pkg::REPLY_INVALID;
      manual_in = manual_ff;
      fan_in    = fan_ff;
      light_in  = light_ff;
      if (hits[tcmc_pkg::CMD_AUTO]) begin
         manual_in = 1'b0;
         reply     = tcmc_pkg::REPLY_AUTO;
      end else if (hits[tcmc_pkg::CMD_MANUAL]) begin
         manual_in = 1'b1;
         reply     = tcmc_pkg::REPLY_MANUAL;
      end else if (hits[tcmc_pkg::CMD_FAN_OFF]) begin
         fan_in = 1'b0;
         reply  = tcmc_pkg::REPLY_NONE;
      end else if (hits[tcmc_pkg::CMD_FAN_ON]) begin
         fan_in = 1'b1;
         reply  = tcmc_pkg::REPLY_NONE;
      end else if (hits[tcmc_pkg::CMD_LED_OFF]) begin
         light_in = 1'b0;
         reply    = tcmc_pkg::REPLY_NONE;
      end else if (hits[tcmc_pkg::CMD_LED_ON]) begin
         light_in = 1'b1;
         reply    = tcmc_pkg::REPLY_NONE;
      end
   end

   // Line state next values
   always_comb begin
      count_in = count_ff;
      match_in = match_ff;
      ended_in = ended_ff;
      if (do_byte && store) begin
         count_in = count_ff + 1'b1;
         if (!ended_ff) begin
            match_in = match_ff & keep;
            ended_in = (rx_byte == tcmc_pkg::CHAR_NUL);
         end
      end else if (do_byte && finish) begin
         count_in = '0;
         match_in = '1;
         ended_in = 1'b0;
      end
   end

   // Status seen by this transaction, state after it
   always_comb begin
      if (do_byte && finish) begin
         status.reply  = reply;
         status.manual = manual_in;
         status.fan    = fan_in;
         status.light  = light_in;
      end else begin
         status.reply  = tcmc_pkg::REPLY_NONE;
         status.manual = manual_ff;
         status.fan    = fan_ff;
         status.light  = light_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         match_ff  <= '1;
         ended_ff  <= 1'b0;
         manual_ff <= 1'b0;
         fan_ff    <= 1'b0;
         light_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         match_ff  <= match_in;
         ended_ff  <= ended_in;
         manual_ff <= status.manual;
         fan_ff    <= status.fan;
         light_ff  <= status.light;
      end
   end

endmodule

FILE: rtl/text_command_mode_controller.sv
// Top level of the text command mode controller.
//
//   Port      Dir   Protocol     Transaction
//   req       in    valid/ready  received byte or sensor sample
//   rsp       out   valid/ready  one result per request
//   csr_*     in/out APB          threshold and duty registers
//
// One transaction per cycle sustained while rsp.ready is high; an accepted request
// passes the input register, then the result register, before its result is valid.
// The byte parser state and mode flags update in the result stage.
// Reset is synchronous; it empties both stages and restores register defaults.
// A stalled result holds the result register and lets one more request into
// the input register before req.ready drops.
`timescale 1ns / 1ps

module text_command_mode_controller (
   input  logic         clock,
   input  logic         reset,
   tcmc_req_if.sink     req,
   tcmc_rsp_if.source   rsp,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // Configuration registers
   logic signed [7:0] hot_threshold_ff;
   logic [11:0]       motion_threshold_ff;
   logic [9:0]        auto_fan_duty_ff;
   logic [9:0]        manual_fan_duty_ff;

   // Input stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_opcode_ff;
   logic [7:0]        s1_byte_ff;
   logic signed [7:0] s1_temp_ff;
   logic [11:0]       s1_ir_ff;

   // Result stage
   logic                rsp_valid_ff, rsp_valid_in;
   logic                kind_ff, kind_in;
   tcmc_pkg::reply_type reply_ff, reply_in;
   logic [9:0]          duty_ff, duty_in;
   logic                light_on_ff, light_on_in;
   logic                motion_ff, motion_in;
   logic                manual_ff, manual_in;
   logic                fan_cmd_ff, fan_cmd_in;
   logic                light_cmd_ff, light_cmd_in;

   logic                     out_free;
   logic                     s2_fire;
   logic                     csr_write;
   logic [1:0]               csr_index;
   logic                     motion;
   logic                     hot;
   tcmc_pkg::cmd_status_type status;

   // Pipeline handshake
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s2_fire   = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || out_free;

   assign s1_valid_in  = req.ready ? req.valid : s1_valid_ff;
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      case (csr_index)
         tcmc_pkg::REG_HOT_THRESHOLD:    csr_prdata = {24'h0, hot_threshold_ff};
         tcmc_pkg::REG_MOTION_THRESHOLD: csr_prdata = {20'h0, motion_threshold_ff};
         tcmc_pkg::REG_AUTO_FAN_DUTY:    csr_prdata = {22'h0, auto_fan_duty_ff};
         tcmc_pkg::REG_MANUAL_FAN_DUTY:  csr_prdata = {22'h0, manual_fan_duty_ff};
         default:                        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hot_threshold_ff    <= tcmc_pkg::HOT_THRESHOLD_RST;
         motion_threshold_ff <= tcmc_pkg::MOTION_THRESHOLD_RST;
         auto_fan_duty_ff    <= tcmc_pkg::AUTO_FAN_DUTY_RST;
         manual_fan_duty_ff  <= tcmc_pkg::MANUAL_FAN_DUTY_RST;
      end else if (csr_pready && csr_write) begin
         case (csr_index)
            tcmc_pkg::REG_HOT_THRESHOLD:    hot_threshold_ff    <= csr_pwdata[7:0];
            tcmc_pkg::REG_MOTION_THRESHOLD: motion_threshold_ff <= csr_pwdata[11:0];
            tcmc_pkg::REG_AUTO_FAN_DUTY:    auto_fan_duty_ff    <= csr_pwdata[9:0];
            tcmc_pkg::REG_MANUAL_FAN_DUTY:  manual_fan_duty_ff  <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   // Command line parser
   tcmc_line_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (s2_fire),
      .byte_item (s1_opcode_ff == tcmc_pkg::OP_BYTE),
      .rx_byte   (s1_byte_ff),
      .status    (status)
   );

   // Sensor evaluation
   assign motion = (s1_ir_ff <= motion_threshold_ff);
   assign hot    = (s1_temp_ff >= hot_threshold_ff);

   always_comb begin
      kind_in      = s1_opcode_ff;
      manual_in    = status.manual;
      fan_cmd_in   = status.fan;
      light_cmd_in = status.light;
      if (s1_opcode_ff == tcmc_pkg::OP_SAMPLE) begin
         reply_in  = tcmc_pkg::REPLY_NONE;
         motion_in = motion;
         if (status.manual) begin
            duty_in     = status.fan ? tcmc_pkg::clamp_duty(manual_fan_duty_ff) : 10'd0;
            light_on_in = status.light;
         end else begin
            duty_in     = hot ? tcmc_pkg::clamp_duty(auto_fan_duty_ff) : 10'd0;
            light_on_in = motion;
         end
      end else begin
         reply_in    = status.reply;
         motion_in   = 1'b0;
         duty_in     = 10'd0;
         light_on_in = 1'b0;
      end
   end

   // Stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready) begin
         s1_opcode_ff <= req.opcode;
         s1_byte_ff   <= req.rx_byte;
         s1_temp_ff   <= req.temperature;
         s1_ir_ff     <= req.ir_level;
      end
      if (s2_fire) begin
         kind_ff      <= kind_in;
         reply_ff     <= reply_in;
         duty_ff      <= duty_in;
         light_on_ff  <= light_on_in;
         motion_ff    <= motion_in;
         manual_ff    <= manual_in;
         fan_cmd_ff   <= fan_cmd_in;
         light_cmd_ff <= light_cmd_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.result_kind   = kind_ff;
   assign rsp.reply_code    = reply_ff;
   assign rsp.fan_duty      = duty_ff;
   assign rsp.light_on      = light_on_ff;
   assign rsp.motion_seen   = motion_ff;
   assign rsp.manual_active = manual_ff;
   assign rsp.fan_command   = fan_cmd_ff;
   assign rsp.light_command = light_cmd_ff;

endmodule

FILE: rtl/tcmc_checker.sv
// Port-level assertions for the command mode controller and their bind.
`timescale 1ns / 1ps
`include "text_command_mode_controller_macros.svh"

module tcmc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       result_kind,
   input logic [1:0] reply_code,
   input logic [9:0] fan_duty,
   input logic       light_on,
   input logic       motion_seen,
   input logic       manual_active,
   input logic       light_command
);

   `TCMC_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "result valid after reset")

   `TCMC_ASSERT(a_stall_holds, rsp_valid && !rsp_ready |=> rsp_valid && $stable(fan_duty) && $stable(reply_code) && $stable(result_kind), "stalled result changed")

   `TCMC_ASSERT(a_byte_quiet, rsp_valid && !result_kind |-> fan_duty == 10'd0 && !light_on && !motion_seen, "byte result drives sensor fields")

   `TCMC_ASSERT(a_duty_range, rsp_valid && result_kind |-> fan_duty <= tcmc_pkg::DUTY_MAX && reply_code == tcmc_pkg::REPLY_NONE, "sample result out of range")

   `TCMC_ASSERT(a_manual_light, rsp_valid && result_kind && manual_active |-> light_on == light_command, "manual light does not follow command")

endmodule

bind text_command_mode_controller tcmc_checker u_tcmc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .result_kind   (rsp.result_kind),
   .reply_code    (rsp.reply_code),
   .fan_duty      (rsp.fan_duty),
   .light_on      (rsp.light_on),
   .motion_seen   (rsp.motion_seen),
   .manual_active (rsp.manual_active),
   .light_command (rsp.light_command)
);

FILE: sim/text_command_mode_controller_tb.sv
// Self-checking testbench of the text command mode controller: directed table, random traffic.
`timescale 1ns / 1ps

module text_command_mode_controller_tb;

   // One input transaction
   typedef struct packed {
      logic              opcode;
      logic [7:0]        rx_byte;
      logic signed [7:0] temperature;
      logic [11:0]       ir_level;
   } item_type;

   // One result transaction
   typedef struct packed {
      logic                kind;
      tcmc_pkg::reply_type reply;
      logic [9:0]          duty;
      logic                light;
      logic                motion;
      logic                manual;
      logic                fan;
      logic                lamp;
   } status_type;

   // Row of the directed table: an item sent count times, hand-typed status on the last one
   typedef struct {
      item_type    item;
      int unsigned count;
      bit          typed;
      status_type  want;
   } step_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tcmc_req_if req_chan ();
   tcmc_rsp_if rsp_chan ();

   text_command_mode_controller DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Command words, in priority order
   string cmd_name [tcmc_pkg::NUM_CMDS] =
      '{"AUTO", "MANUEL", "FAN OFF", "FAN ON", "LED OFF", "LED ON"};

   // Shadow copy of the configuration registers
   logic signed [7:0] hot_limit;
   logic [11:0]       motion_limit;
   logic [9:0]        auto_duty;
   logic [9:0]        manual_duty;

   // Shadow copy of the line parser and the mode flags
   int unsigned                   line_len;
   logic [tcmc_pkg::NUM_CMDS-1:0] still_possible;
   bit                            nul_seen;
   bit                            mode_manual;
   bit                            fan_on;
   bit                            led_on;

   status_type  expected_status [$];
   step_type    script [$];
   int unsigned items_sent;
   bit          failed;
   bit          calm;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit on the run
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int unsigned draw_wait();
      return calm ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic void clear_line();
      line_len       = 0;
      still_possible = '1;
      nul_seen       = 1'b0;
   endfunction

   // End of a non-empty line: pick the first surviving command
   function automatic tcmc_pkg::reply_type close_line();
      logic [tcmc_pkg::NUM_CMDS-1:0] hits;
      tcmc_pkg::reply_type           reply;
      bit                            done;
      hits  = still_possible;
      reply = tcmc_pkg::REPLY_INVALID;
      done  = 1'b0;
      // without a NUL the whole line has to match the command length
      if (!nul_seen)
         for (int k = 0; k < tcmc_pkg::NUM_CMDS; k++)
            if (cmd_name[k].len() != line_len) hits[k] = 1'b0;
      for (int k = 0; k < tcmc_pkg::NUM_CMDS; k++) begin
         if (hits[k] && !done) begin
            done = 1'b1;
            case (k)
               tcmc_pkg::CMD_AUTO: begin
                  mode_manual = 1'b0;
                  reply = tcmc_pkg::REPLY_AUTO;
               end
               tcmc_pkg::CMD_MANUAL: begin
                  mode_manual = 1'b1;
                  reply = tcmc_pkg::REPLY_MANUAL;
               end
               tcmc_pkg::CMD_FAN_OFF: begin
                  fan_on = 1'b0;
                  reply = tcmc_pkg::REPLY_NONE;
               end
               tcmc_pkg::CMD_FAN_ON: begin
                  fan_on = 1'b1;
                  reply = tcmc_pkg::REPLY_NONE;
               end
               tcmc_pkg::CMD_LED_OFF: begin
                  led_on = 1'b0;
                  reply = tcmc_pkg::REPLY_NONE;
               end
               tcmc_pkg::CMD_LED_ON: begin
                  led_on = 1'b1;
                  reply = tcmc_pkg::REPLY_NONE;
               end
               default: ;
            endcase
         end
      end
      clear_line();
      return reply;
   endfunction

   // Expected result of one accepted item; advances the shadow state
   function automatic status_type predict_status(item_type it);
      status_type s;
      logic [9:0] asked;
      bit         keep;
      s = '0;
      s.kind = it.opcode;
      if (it.opcode == tcmc_pkg::OP_BYTE) begin
         if (it.rx_byte != tcmc_pkg::CHAR_CR && it.rx_byte != tcmc_pkg::CHAR_LF &&
             line_len < tcmc_pkg::LINE_BYTES - 1) begin
            // incremental match, frozen once a NUL has ended the compared text
            if (!nul_seen) begin
               for (int k = 0; k < tcmc_pkg::NUM_CMDS; k++) begin
                  if (it.rx_byte == tcmc_pkg::CHAR_NUL)
                     keep = (cmd_name[k].len() == line_len);
                  else
                     keep = (line_len < cmd_name[k].len()) &&
                            (cmd_name[k][line_len] == it.rx_byte);
                  if (!keep) still_possible[k] = 1'b0;
               end
               if (it.rx_byte == tcmc_pkg::CHAR_NUL) nul_seen = 1'b1;
            end
            line_len++;
         end else if (line_len > 0) begin
            // terminator, or the byte dropped on a full line
            s.reply = close_line();
         end
      end else begin
         s.motion = (it.ir_level <= motion_limit);
         if (mode_manual) begin
            asked   = fan_on ? manual_duty : 10'd0;
            s.light = led_on;
         end else begin
            asked   = ($signed(it.temperature) >= $signed(hot_limit)) ? auto_duty : 10'd0;
            s.light = s.motion;
         end
         s.duty = (asked > tcmc_pkg::DUTY_MAX) ? tcmc_pkg::DUTY_MAX : asked;
      end
      s.manual = mode_manual;
      s.fan    = fan_on;
      s.lamp   = led_on;
      return s;
   endfunction

   function automatic item_type char_item(logic [7:0] b);
      item_type it;
      it.opcode      = tcmc_pkg::OP_BYTE;
      it.rx_byte     = b;
      it.temperature = 8'($urandom);
      it.ir_level    = 12'($urandom);
      return it;
   endfunction

   function automatic item_type sample_item(logic signed [7:0] t, logic [11:0] ir);
      item_type it;
      it.opcode      = tcmc_pkg::OP_SAMPLE;
      it.rx_byte     = 8'($urandom);
      it.temperature = t;
      it.ir_level    = ir;
      return it;
   endfunction

   function automatic status_type status(logic kind, tcmc_pkg::reply_type reply,
                                         logic [9:0] duty, logic light, logic motion,
                                         logic manual, logic fan, logic lamp);
      return '{kind, reply, duty, light, motion, manual, fan, lamp};
   endfunction

   function automatic step_type row(item_type it, int unsigned count = 1);
      return '{it, count, 1'b0, '0};
   endfunction

   function automatic step_type checked(item_type it, status_type want, int unsigned count = 1);
      return '{it, count, 1'b1, want};
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) script.push_back(row(char_item(s[i])));
   endfunction

   // Drive one item and record its expected status once it is taken
   task automatic send(input item_type it, input bit typed, input status_type want);
      int unsigned gap;
      status_type  predicted;
      gap = draw_wait();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.opcode      <= it.opcode;
      req_chan.rx_byte     <= it.rx_byte;
      req_chan.temperature <= it.temperature;
      req_chan.ir_level    <= it.ir_level;
      do @(posedge clock); while (!req_chan.ready);
      predicted = predict_status(it);
      expected_status.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic send_bytes(input logic [7:0] bytes [$]);
      foreach (bytes[i]) send(char_item(bytes[i]), 1'b0, '0);
   endtask

   // Hold the sender until every pending result has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_status.size() != 0);
   endtask

   // APB write: setup then access; psel stays up across back-to-back writes
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         tcmc_pkg::REG_HOT_THRESHOLD:    hot_limit    = value[7:0];
         tcmc_pkg::REG_MOTION_THRESHOLD: motion_limit = value[11:0];
         tcmc_pkg::REG_AUTO_FAN_DUTY:    auto_duty    = value[9:0];
         tcmc_pkg::REG_MANUAL_FAN_DUTY:  manual_duty  = value[9:0];
         default: ;
      endcase
   endtask

   // Register settings per phase: both extremes, a near-default one, random otherwise
   task automatic load_registers(input int phase);
      logic [31:0] hot, motion, auto_d, manual_d;
      case (phase)
         1: begin
            hot = 32'h80; motion = 32'd4095; auto_d = 32'd1023; manual_d = 32'd1023;
         end
         2: begin
            hot = 32'h7f; motion = 32'd0; auto_d = 32'd0; manual_d = 32'd0;
         end
         4: begin
            hot = 32'd27; motion = 32'd1500; auto_d = 32'd999; manual_d = 32'd1000;
         end
         default: begin
            hot      = $urandom_range(0, 255);
            motion   = $urandom_range(0, 4095);
            auto_d   = $urandom_range(0, 1023);
            manual_d = $urandom_range(0, 1023);
         end
      endcase
      write_reg(tcmc_pkg::REG_HOT_THRESHOLD, hot);
      write_reg(tcmc_pkg::REG_MOTION_THRESHOLD, motion);
      write_reg(tcmc_pkg::REG_AUTO_FAN_DUTY, auto_d);
      write_reg(tcmc_pkg::REG_MANUAL_FAN_DUTY, manual_d);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failed = 1'b1;
      end
   endtask

   // Result side: random stalls, compare each result with the oldest expectation
   int unsigned rsp_wait = 0;
   always @(posedge clock) begin : result_sink
      status_type got;
      status_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.kind   = rsp_chan.result_kind;
         got.reply  = rsp_chan.reply_code;
         got.duty   = rsp_chan.fan_duty;
         got.light  = rsp_chan.light_on;
         got.motion = rsp_chan.motion_seen;
         got.manual = rsp_chan.manual_active;
         got.fan    = rsp_chan.fan_command;
         got.lamp   = rsp_chan.light_command;
         if (expected_status.size() == 0) begin
            $error("result transaction with nothing pending");
            failed = 1'b1;
         end else begin
            want = expected_status.pop_front();
            check_field("result_kind", want.kind, got.kind);
            check_field("reply_code", want.reply, got.reply);
            check_field("fan_duty", want.duty, got.duty);
            check_field("light_on", want.light, got.light);
            check_field("motion_seen", want.motion, got.motion);
            check_field("manual_active", want.manual, got.manual);
            check_field("fan_command", want.fan, got.fan);
            check_field("light_command", want.lamp, got.lamp);
         end
         rsp_wait = draw_wait();
      end else if (rsp_wait > 0) begin
         rsp_wait--;
      end
      rsp_chan.ready <= (rsp_wait == 0);
   end

   // Stimulus
   initial begin
      int unsigned       phase_start;
      int unsigned       pick;
      int unsigned       cmd;
      logic [7:0]        line [$];
      logic signed [7:0] t;
      logic [11:0]       ir;

      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.opcode      = tcmc_pkg::OP_BYTE;
      req_chan.rx_byte     = '0;
      req_chan.temperature = '0;
      req_chan.ir_level    = '0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      calm                 = 1'b0;
      failed               = 1'b0;
      items_sent           = 0;

      // shadow state after reset
      hot_limit    = tcmc_pkg::HOT_THRESHOLD_RST;
      motion_limit = tcmc_pkg::MOTION_THRESHOLD_RST;
      auto_duty    = tcmc_pkg::AUTO_FAN_DUTY_RST;
      manual_duty  = tcmc_pkg::MANUAL_FAN_DUTY_RST;
      mode_manual  = 1'b0;
      fan_on       = 1'b0;
      led_on       = 1'b0;
      clear_line();

      // Directed table: threshold edges, empty lines, each mode, NUL and full-line cases
      script.push_back(checked(sample_item(8'sd27, 12'd1500),
                               status(tcmc_pkg::OP_SAMPLE, tcmc_pkg::REPLY_NONE, 10'd500,
                                      1'b1, 1'b1, 1'b0, 1'b0, 1'b0)));
      script.push_back(checked(sample_item(8'sd26, 12'd1501),
                               status(tcmc_pkg::OP_SAMPLE, tcmc_pkg::REPLY_NONE, 10'd0,
                                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0)));
      script.push_back(checked(sample_item(-8'sd128, 12'd4095),
                               status(tcmc_pkg::OP_SAMPLE, tcmc_pkg::REPLY_NONE, 10'd0,
                                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0)));
      script.push_back(checked(sample_item(8'sd127, 12'd0),
                               status(tcmc_pkg::OP_SAMPLE, tcmc_pkg::REPLY_NONE, 10'd500,
                                      1'b1, 1'b1, 1'b0, 1'b0, 1'b0)));
      script.push_back(checked(char_item(tcmc_pkg::CHAR_CR),
                               status(tcmc_pkg::OP_BYTE, tcmc_pkg::REPLY_NONE, 10'd0,
                                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0)));
      script.push_back(checked(char_item(tcmc_pkg::CHAR_LF),
                               status(tcmc_pkg::OP_BYTE, tcmc_pkg::REPLY_NONE, 10'd0,
                                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0)));
      add_text("MANUEL");
      script.push_back(checked(char_item(tcmc_pkg::CHAR_CR),
                               status(tcmc_pkg::OP_BYTE, tcmc_pkg::REPLY_MANUAL, 10'd0,
                                      1'b0, 1'b0, 1'b1, 1'b0, 1'b0)));
      add_text("LED ON");
      script.push_back(checked(char_item(tcmc_pkg::CHAR_LF),
                               status(tcmc_pkg::OP_BYTE, tcmc_pkg::REPLY_NONE, 10'd0,
                                      1'b0, 1'b0, 1'b1, 1'b0, 1'b1)));
      script.push_back(checked(sample_item(8'sd127, 12'd4095),
                               status(tcmc_pkg::OP_SAMPLE, tcmc_pkg::REPLY_NONE, 10'd0,
                                      1'b1, 1'b0, 1'b1, 1'b0, 1'b1)));
      add_text("FAN ON");
      script.push_back(row(char_item(tcmc_pkg::CHAR_CR)));
      script.push_back(checked(sample_item(8'sd0, 12'd0),
                               status(tcmc_pkg::OP_SAMPLE, tcmc_pkg::REPLY_NONE, 10'd300,
                                      1'b1, 1'b1, 1'b1, 1'b1, 1'b1)));
      // text after a NUL is counted but not compared
      add_text("AUTO");
      script.push_back(row(char_item(tcmc_pkg::CHAR_NUL)));
      script.push_back(row(char_item("X")));
      script.push_back(checked(char_item(tcmc_pkg::CHAR_CR),
                               status(tcmc_pkg::OP_BYTE, tcmc_pkg::REPLY_AUTO, 10'd0,
                                      1'b0, 1'b0, 1'b0, 1'b1, 1'b1)));
      // the byte after a full line is dropped and closes it
      script.push_back(checked(char_item("Z"),
                               status(tcmc_pkg::OP_BYTE, tcmc_pkg::REPLY_INVALID, 10'd0,
                                      1'b0, 1'b0, 1'b0, 1'b1, 1'b1), 64));
      script.push_back(row(char_item(tcmc_pkg::CHAR_NUL)));
      script.push_back(checked(char_item(tcmc_pkg::CHAR_CR),
                               status(tcmc_pkg::OP_BYTE, tcmc_pkg::REPLY_INVALID, 10'd0,
                                      1'b0, 1'b0, 1'b0, 1'b1, 1'b1)));
      script.push_back(row(char_item(8'hff)));
      script.push_back(checked(char_item(tcmc_pkg::CHAR_LF),
                               status(tcmc_pkg::OP_BYTE, tcmc_pkg::REPLY_INVALID, 10'd0,
                                      1'b0, 1'b0, 1'b0, 1'b1, 1'b1)));
      add_text("FAN OFF");
      script.push_back(row(char_item(tcmc_pkg::CHAR_CR)));
      add_text("LED OFF");
      script.push_back(row(char_item(tcmc_pkg::CHAR_LF)));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i])
         for (int n = 1; n <= script[i].count; n++)
            send(script[i].item, script[i].typed && n == script[i].count, script[i].want);
      drain();

      // Random phases, one register setting each
      for (int phase = 1; phase <= 5; phase++) begin
         load_registers(phase);
         calm = (phase == 3);
         phase_start = items_sent;
         while (items_sent - phase_start < 56) begin
            if ($urandom_range(0, 29) == 0) drain();
            pick = $urandom_range(0, 99);
            line.delete();
            if (pick < 55) begin
               // command line, sometimes damaged
               cmd = $urandom_range(0, tcmc_pkg::NUM_CMDS - 1);
               for (int i = 0; i < cmd_name[cmd].len(); i++) line.push_back(cmd_name[cmd][i]);
               case ($urandom_range(0, 9))
                  0: begin
                     line.push_back(tcmc_pkg::CHAR_NUL);
                     repeat ($urandom_range(0, 3)) line.push_back(8'($urandom));
                  end
                  1: line[$urandom_range(0, line.size() - 1)] = 8'($urandom);
                  2: void'(line.pop_back());
                  3: line.push_back(8'($urandom_range(8'h20, 8'h7e)));
                  default: ;
               endcase
               line.push_back($urandom_range(0, 1) ? tcmc_pkg::CHAR_CR : tcmc_pkg::CHAR_LF);
               if ($urandom_range(0, 7) == 0) line.push_back(tcmc_pkg::CHAR_LF);
               send_bytes(line);
            end else if (pick < 80) begin
               // sample, often close to the thresholds
               t  = $urandom_range(0, 1) ? 8'($urandom)
                                         : 8'(hot_limit + $urandom_range(0, 2) - 1);
               ir = $urandom_range(0, 1) ? 12'($urandom)
                                         : 12'(motion_limit + $urandom_range(0, 2) - 1);
               send(sample_item(t, ir), 1'b0, '0);
            end else if (pick < 95) begin
               send(char_item(8'($urandom)), 1'b0, '0);
            end else begin
               // long line, may overrun the buffer
               repeat ($urandom_range(56, 70)) line.push_back(8'($urandom_range(8'h20, 8'h7e)));
               line.push_back(tcmc_pkg::CHAR_CR);
               send_bytes(line);
            end
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (!failed)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tcmc_pkg.sv
rtl/tcmc_if.sv
rtl/tcmc_line_parser.sv
rtl/text_command_mode_controller.sv
rtl/tcmc_checker.sv
sim/text_command_mode_controller_tb.sv
